### hw/rtl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CfgPhaseTicks = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgAckLimit   = 1'b1;

  localparam logic [15:0] PhaseTicksRst = 16'd2;
  localparam logic [7:0]  AckLimitRst   = 8'd250;

  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  localparam logic [1:0] StepDev  = 2'd0;
  localparam logic [1:0] StepReg  = 2'd1;
  localparam logic [1:0] StepData = 2'd2;
  localparam logic [1:0] StepRead = 2'd3;

  typedef enum logic [18:0] {
    PH_IDLE   = 19'h00001,
    PH_ST1    = 19'h00002,
    PH_ST2    = 19'h00004,
    PH_ST3    = 19'h00008,
    PH_TX1    = 19'h00010,
    PH_TX2    = 19'h00020,
    PH_TX3    = 19'h00040,
    PH_AK1    = 19'h00080,
    PH_AK2    = 19'h00100,
    PH_AKPOLL = 19'h00200,
    PH_AK3    = 19'h00400,
    PH_RX1    = 19'h00800,
    PH_RX2    = 19'h01000,
    PH_NK1    = 19'h02000,
    PH_NK2    = 19'h04000,
    PH_NK3    = 19'h08000,
    PH_SP1    = 19'h10000,
    PH_SP2    = 19'h20000,
    PH_SP3    = 19'h40000
  } phase_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [7:0]  ack_wait_limit;
  } cfg_t;

  typedef struct packed {
    logic       ack_error;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/i2cm_core.sv
`default_nettype none

module i2cm_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire i2cm_pkg::item_t item_i,
  input  wire i2cm_pkg::cfg_t  cfg_i,
  output i2cm_pkg::res_t       res_o
);
  import i2cm_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [1:0]  byte_step_q, byte_step_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  polls_q, polls_d;
  logic [1:0]  op_q, op_d;
  logic [6:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d;
  logic [7:0]  wdata_q, wdata_d;
  logic [7:0]  rx_byte_q, rx_byte_d;
  logic        err_q, err_d;
  logic        done;
  logic [15:0] pt;
  logic [15:0] tick_inc;
  logic [3:0]  bit_inc;
  logic        tx_bit;

  assign pt       = (cfg_i.phase_ticks == 16'd0) ? 16'd1 : cfg_i.phase_ticks;
  assign tick_inc = tick_q + 16'd1;
  assign bit_inc  = bit_cnt_q + 4'd1;

  always_comb begin
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    shift_d     = shift_q;
    byte_step_d = byte_step_q;
    tick_d      = tick_q;
    polls_d     = polls_q;
    op_d        = op_q;
    dev_d       = dev_q;
    reg_d       = reg_q;
    wdata_d     = wdata_q;
    rx_byte_d   = rx_byte_q;
    err_d       = err_q;
    done        = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (item_i.opcode == OpWrite || item_i.opcode == OpRead) begin
          op_d        = item_i.opcode;
          dev_d       = item_i.dev_addr;
          reg_d       = item_i.reg_addr;
          wdata_d     = item_i.write_data;
          byte_step_d = StepDev;
          bit_cnt_d   = 4'd0;
          err_d       = 1'b0;
          phase_d     = PH_ST1;
          tick_d      = 16'd0;
        end
      end
      PH_AKPOLL: begin
        if (!item_i.sda_in) begin
          phase_d = PH_AK3;
          tick_d  = 16'd0;
        end else if (polls_q >= cfg_i.ack_wait_limit) begin
          err_d   = 1'b1;
          phase_d = PH_SP1;
          tick_d  = 16'd0;
        end else begin
          polls_d = polls_q + 8'd1;
        end
      end
      default: begin
        tick_d = tick_inc;
        if (tick_inc >= pt) begin
          tick_d = 16'd0;
          case (phase_q)
            PH_ST1: phase_d = PH_ST2;
            PH_ST2: phase_d = PH_ST3;
            PH_ST3: begin
              shift_d   = {dev_q, byte_step_q == StepData};
              bit_cnt_d = 4'd0;
              phase_d   = PH_TX1;
            end
            PH_TX1: phase_d = PH_TX2;
            PH_TX2: phase_d = PH_TX3;
            PH_TX3: begin
              shift_d   = {shift_q[6:0], 1'b0};
              bit_cnt_d = bit_inc;
              phase_d   = (bit_inc >= 4'd8) ? PH_AK1 : PH_TX1;
            end
            PH_AK1: phase_d = PH_AK2;
            PH_AK2: begin
              polls_d = 8'd0;
              phase_d = PH_AKPOLL;
            end
            PH_AK3: begin
              if (byte_step_q == StepDev) begin
                byte_step_d = StepReg;
                shift_d     = reg_q;
                bit_cnt_d   = 4'd0;
                phase_d     = PH_TX1;
              end else if (byte_step_q == StepReg) begin
                byte_step_d = StepData;
                if (op_q == OpWrite) begin
                  shift_d   = wdata_q;
                  bit_cnt_d = 4'd0;
                  phase_d   = PH_TX1;
                end else begin
                  phase_d = PH_ST1;
                end
              end else if (byte_step_q == StepData && op_q == OpRead) begin
                byte_step_d = StepRead;
                bit_cnt_d   = 4'd0;
                shift_d     = 8'd0;
                phase_d     = PH_RX1;
              end else begin
                phase_d = PH_SP1;
              end
            end
            PH_RX1: begin
              shift_d = {shift_q[6:0], item_i.sda_in};
              phase_d = PH_RX2;
            end
            PH_RX2: begin
              bit_cnt_d = bit_inc;
              if (bit_inc >= 4'd8) begin
                rx_byte_d = shift_q;
                phase_d   = PH_NK1;
              end else begin
                phase_d = PH_RX1;
              end
            end
            PH_NK1: phase_d = PH_NK2;
            PH_NK2: phase_d = PH_NK3;
            PH_NK3: phase_d = PH_SP1;
            PH_SP1: phase_d = PH_SP2;
            PH_SP2: phase_d = PH_SP3;
            PH_SP3: begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end
    endcase
  end

  assign tx_bit = shift_d[7];

  always_comb begin
    res_o.scl_out   = 1'b1;
    res_o.sda_out   = 1'b1;
    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.done_res  = done;
    res_o.read_data = rx_byte_d;
    res_o.ack_error = err_d;
    case (phase_d)
      PH_ST2: res_o.sda_out = 1'b0;
      PH_ST3: begin
        res_o.scl_out = 1'b0;
        res_o.sda_out = 1'b0;
      end
      PH_TX1: begin
        res_o.scl_out = 1'b0;
        res_o.sda_out = tx_bit;
      end
      PH_TX2: res_o.sda_out = tx_bit;
      PH_TX3: begin
        res_o.scl_out = 1'b0;
        res_o.sda_out = (bit_cnt_d == 4'd7) ? 1'b1 : tx_bit;
      end
      PH_AK1, PH_AK3, PH_RX2, PH_NK1, PH_NK3: res_o.scl_out = 1'b0;
      PH_SP1: begin
        res_o.scl_out = 1'b0;
        res_o.sda_out = 1'b0;
      end
      PH_SP2: res_o.sda_out = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_cnt_q   <= 4'd0;
      shift_q     <= 8'd0;
      byte_step_q <= StepDev;
      tick_q      <= 16'd0;
      polls_q     <= 8'd0;
      op_q        <= 2'd0;
      dev_q       <= 7'd0;
      reg_q       <= 8'd0;
      wdata_q     <= 8'd0;
      rx_byte_q   <= 8'd0;
      err_q       <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      bit_cnt_q   <= bit_cnt_d;
      shift_q     <= shift_d;
      byte_step_q <= byte_step_d;
      tick_q      <= tick_d;
      polls_q     <= polls_d;
      op_q        <= op_d;
      dev_q       <= dev_d;
      reg_q       <= reg_d;
      wdata_q     <= wdata_d;
      rx_byte_q   <= rx_byte_d;
      err_q       <= err_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/i2c_master_register_access.sv
// Channel    Dir  Handshake                      Payload
// s_axis     in   s_axis_tvalid_i/tready_o       tdata: opcode, dev_addr, reg_addr,
//                                                write_data, sda_in
// m_axis     out  m_axis_tvalid_o/tready_i       tdata: scl_out, sda_out, busy_res,
//                                                done_res, read_data, ack_error
// cfg        in   cfg_we_i                       cfg_index_i, cfg_data_i
//
// One item per clock while tready is high; each item yields one result, registered and shown in the next cycle.
// The sequencer step sits between the state registers and the output register.
// tready drops only while the output register holds a result not yet taken.
// Reset is asynchronous and returns the bus sequencer to idle.
`default_nettype none

module i2c_master_register_access (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // opcode[1:0], dev_addr[8:2], reg_addr[16:9], write_data[24:17], sda_in[25]
  input  wire logic [i2cm_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // scl_out[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4], ack_error[12]
  output logic [i2cm_pkg::OutDataW-1:0]       m_axis_tdata_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [i2cm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [i2cm_pkg::CfgDataW-1:0]  cfg_data_i
);
  import i2cm_pkg::*;

  item_t item;
  cfg_t  cfg_q;
  res_t  res;
  res_t  out_q;
  logic  out_valid_q;
  logic  step;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign step            = s_axis_tvalid_i && s_axis_tready_o;

  assign item.opcode     = s_axis_tdata_i[1:0];
  assign item.dev_addr   = s_axis_tdata_i[8:2];
  assign item.reg_addr   = s_axis_tdata_i[16:9];
  assign item.write_data = s_axis_tdata_i[24:17];
  assign item.sda_in     = s_axis_tdata_i[25];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_ticks    <= PhaseTicksRst;
      cfg_q.ack_wait_limit <= AckLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgPhaseTicks: cfg_q.phase_ticks    <= cfg_data_i;
        CfgAckLimit:   cfg_q.ack_wait_limit <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  i2cm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.ack_error, out_q.read_data, out_q.done_res,
                            out_q.busy_res, out_q.sda_out, out_q.scl_out};

endmodule

`default_nettype wire

### hw/rtl/i2cm_checker.sv
`default_nettype none

module i2cm_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tready_o,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [i2cm_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  // done marks the return to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[3] |-> !m_axis_tdata_o[2])
    else $error("done with busy set");

  // idle bus releases both lines
  a_idle_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[2] |-> m_axis_tdata_o[0] && m_axis_tdata_o[1])
    else $error("line held low while idle");

  // stall only with a pending result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped under stall");

endmodule

bind i2c_master_register_access i2cm_checker u_i2cm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
